// ----- rtl/qbwg_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the quadratic B-spline weight and gradient pipeline.
// Used by the datapath top level and by its port checker; depends on nothing.
package qbwg_pkg;

  // Fractional bits of the Q-format positions, spacing and gradients.
  localparam int FRAC_BITS = 16;

  // Field widths on the streams.
  localparam int COORD_W  = 32;
  localparam int WEIGHT_W = 16;
  localparam int AXES     = 3;

  // Packed stream widths (whole bytes).
  localparam int IN_DATA_W  = 6 * COORD_W;
  localparam int OUT_DATA_W = WEIGHT_W + 3 * COORD_W;

  // Support limit 1.5 in Q.2F on the exact offset |r|.
  localparam logic [63:0] LIM_2F = 64'(3) << (2 * FRAC_BITS - 1);

  // Alignment of the exact offset to Q.30.
  localparam int SH     = 2 * FRAC_BITS - 30;
  localparam int SH_POS = (SH >= 0) ? SH : 0;
  localparam int SH_NEG = (SH >= 0) ? 0 : -SH;

  // Q.30 constants of the basis.
  localparam logic [30:0] HALF30          = 31'(1) << 29;
  localparam logic [30:0] THREE_HALF30    = 31'(3) << 29;
  localparam logic [29:0] THREE_QUARTER30 = 30'(3) << 28;

  // Reset value of the reciprocal spacing: 1.0.
  localparam logic [31:0] INV_RESET = 32'(1) << FRAC_BITS;

  // Largest weight the kernel can give: 0.75^3 in Q0.16.
  localparam logic [WEIGHT_W-1:0] WEIGHT_PEAK = 16'd27648;

  // Gradient saturation bounds.
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAG = 32'h8000_0000;

endpackage

// ----- rtl/quadratic_bspline_weight_gradient.sv -----
`timescale 1ns / 1ps
// Quadratic B-spline weight and gradient kernel for 3D particle/node pairs.
// Nine-stage pipeline; depends on qbwg_pkg.
//
// The block accepts one particle/node pair per clock cycle unless the output
// is stalled and returns one result per pair, in order. Its datapath has
// nine register stages: difference, offset multiply, support test, square,
// basis, pairwise weight products, slope products, spacing scale and
// saturation. All stages advance together; when
// the output register holds a result that is not taken, the whole pipeline
// holds and s_axis_tready drops in the same cycle, so nothing is lost or
// repeated. inv_cell_size resets to 1.0 and may be written only while the
// pipeline is empty.
module quadratic_bspline_weight_gradient (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration: reciprocal grid spacing, unsigned Q16.16.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [31:0]                       cfg_data,
  // Input pairs.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // particle_x, particle_y, particle_z, node_x, node_y, node_z (32 bits each)
  input  logic [qbwg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // Results.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // weight (16), grad_x (32), grad_y (32), grad_z (32)
  output logic [qbwg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // in_support (1)
  output logic                              m_axis_tuser
);
  import qbwg_pkg::*;

  // Configuration register; always ready.
  logic [31:0] inv_cell_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cell_size <= INV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      inv_cell_size <= cfg_data;
    end
  end

  // Global advance: every stage moves unless the output is stalled.
  logic       adv;
  logic [8:0] vld;

  assign adv           = !(m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[7:0], s_axis_tvalid};
    end
  end

  // Stage registers.
  logic [31:0] dmag1 [AXES];
  logic [2:0]  pos1;
  logic [63:0] r2 [AXES];
  logic [2:0]  pos2;
  logic [30:0] sel3 [AXES];
  logic [30:0] m3 [AXES];
  logic [2:0]  near3, pos3;
  logic        inside3;
  logic [61:0] sq4 [AXES];
  logic [30:0] m4 [AXES];
  logic [2:0]  near4, pos4;
  logic        inside4;
  logic [29:0] w5 [AXES];
  logic [30:0] m5 [AXES];
  logic [2:0]  pos5;
  logic        inside5;
  logic [29:0] w01_6, w02_6, w12_6, w2_6;
  logic [30:0] m6 [AXES];
  logic [2:0]  pos6;
  logic        inside6;
  logic [15:0] wt7;
  logic [29:0] q7 [AXES];
  logic [2:0]  pos7;
  logic        inside7;
  logic [15:0] wt8;
  logic [31:0] g8 [AXES];
  logic [2:0]  pos8;
  logic        inside8;
  logic [31:0] grad9 [AXES];
  logic [15:0] wt9;
  logic        inside9;

  // Stage 1: exact axis differences and their magnitudes.
  logic [32:0] diff [AXES];
  logic [32:0] dabs [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      diff[i] = {s_axis_tdata[i*COORD_W + COORD_W-1], s_axis_tdata[i*COORD_W +: COORD_W]}
              - {s_axis_tdata[(i+3)*COORD_W + COORD_W-1],
                 s_axis_tdata[(i+3)*COORD_W +: COORD_W]};
      dabs[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        dmag1[i] <= dabs[i][31:0];
        pos1[i]  <= !diff[i][32] && (diff[i] != 33'd0);
      end
    end
  end

  // Stage 2: exact normalized offset magnitude in Q.2F.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        r2[i] <= 64'(dmag1[i]) * 64'(inv_cell_size);
      end
      pos2 <= pos1;
    end
  end

  // Stage 3: support test, Q.30 offset, square operand and slope magnitude.
  logic [63:0] afull [AXES];
  logic [30:0] a3 [AXES];
  logic [2:0]  out3;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      afull[i] = (SH >= 0) ? (r2[i] >> SH_POS) : (r2[i] << SH_NEG);
      a3[i]    = afull[i][30:0];
      out3[i]  = r2[i] >= LIM_2F;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        near3[i] <= a3[i] < HALF30;
        sel3[i]  <= (a3[i] < HALF30) ? a3[i] : (THREE_HALF30 - a3[i]);
        m3[i]    <= (a3[i] <= HALF30) ? {a3[i][29:0], 1'b0} : (THREE_HALF30 - a3[i]);
      end
      inside3 <= ~|out3;
      pos3    <= pos2;
    end
  end

  // Stage 4: square of the basis operand.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        sq4[i] <= 62'(sel3[i]) * 62'(sel3[i]);
        m4[i]  <= m3[i];
      end
      near4   <= near3;
      pos4    <= pos3;
      inside4 <= inside3;
    end
  end

  // Stage 5: 1D basis values in Q.30.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        w5[i] <= near4[i] ? (THREE_QUARTER30 - sq4[i][59:30]) : sq4[i][60:31];
        m5[i] <= m4[i];
      end
      pos5    <= pos4;
      inside5 <= inside4;
    end
  end

  // Stage 6: pairwise products of the basis values.
  logic [59:0] p01, p02, p12;

  assign p01 = 60'(w5[0]) * 60'(w5[1]);
  assign p02 = 60'(w5[0]) * 60'(w5[2]);
  assign p12 = 60'(w5[1]) * 60'(w5[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      w01_6   <= p01[59:30];
      w02_6   <= p02[59:30];
      w12_6   <= p12[59:30];
      w2_6    <= w5[2];
      m6      <= m5;
      pos6    <= pos5;
      inside6 <= inside5;
    end
  end

  // Stage 7: product weight and slope-weight products.
  logic [59:0] pwt;
  logic [60:0] pq [AXES];

  always_comb begin
    pwt   = 60'(w01_6) * 60'(w2_6);
    pq[0] = 61'(m6[0]) * 61'(w12_6);
    pq[1] = 61'(m6[1]) * 61'(w02_6);
    pq[2] = 61'(m6[2]) * 61'(w01_6);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wt7 <= pwt[59:44];
      for (int i = 0; i < AXES; i++) begin
        q7[i] <= pq[i][59:30];
      end
      pos7    <= pos6;
      inside7 <= inside6;
    end
  end

  // Stage 8: scale by the reciprocal spacing back to Q.F.
  logic [61:0] pg [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      pg[i] = 62'(inv_cell_size) * 62'(q7[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        g8[i] <= pg[i][61:30];
      end
      wt8     <= wt7;
      pos8    <= pos7;
      inside8 <= inside7;
    end
  end

  // Stage 9: sign, saturation and the out-of-support mask into the output register.
  logic [31:0] gsat [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (!inside8) begin
        gsat[i] = '0;
      end else if (pos8[i]) begin
        gsat[i] = (g8[i] > NEG_MAG) ? NEG_MAG : (32'd0 - g8[i]);
      end else begin
        gsat[i] = (g8[i] > POS_MAX) ? POS_MAX : g8[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grad9   <= gsat;
      wt9     <= inside8 ? wt8 : '0;
      inside9 <= inside8;
    end
  end

  assign m_axis_tdata = {grad9[2], grad9[1], grad9[0], wt9};
  assign m_axis_tuser = inside9;

endmodule

// ----- rtl/qbwg_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the B-spline weight and gradient block, bound to the top level.
// Depends on qbwg_pkg for the stream widths and the weight peak.
module qbwg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [qbwg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic                              m_axis_tuser
);
  import qbwg_pkg::*;

  // A stalled result keeps its data and flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A pair outside the support carries zero weight and zero gradient.
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("out-of-support result is not zero");

  // The weight never exceeds the peak of the kernel.
  a_weight_peak: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[WEIGHT_W-1:0] <= WEIGHT_PEAK)
    else $error("weight above kernel peak");

  // Requests are refused only while a result waits at the output.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result presented right after reset");

endmodule

bind quadratic_bspline_weight_gradient qbwg_checker u_qbwg_checker (.*);
